/* sv/shape_pair_collision_test_core_assert.svh */
// Assertion macros shared by the collision test core.
`ifndef SHAPE_PAIR_COLLISION_TEST_CORE_ASSERT_SVH
`define SHAPE_PAIR_COLLISION_TEST_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SPCT_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("collision core check failed");

// Next-cycle implication, disabled during reset.
`define SPCT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("collision core check failed");

`endif

/* sv/spct_pkg.sv */
// Types, codes and helpers for the shape pair collision test core.
package spct_pkg;

	localparam logic KIND_CIRCLE = 1'b0;
	localparam logic KIND_BOX    = 1'b1;

	typedef enum logic [1:0] {
		MODE_CC,
		MODE_CB,
		MODE_BB
	} mode_t;

	typedef enum logic [1:0] {
		EDGE_LEFT,
		EDGE_RIGHT,
		EDGE_BOTTOM,
		EDGE_TOP
	} edge_t;

	// Everything an item needs after the squared distance is known.
	typedef struct packed {
		logic        hit;
		logic        use_root;
		logic        neg_x;
		logic        neg_y;
		logic [31:0] mag_x;
		logic [31:0] mag_y;
		logic [31:0] rsum;
		logic [15:0] fix_nx;
		logic [15:0] fix_ny;
		logic [31:0] fix_depth;
	} trk_t;

	typedef struct packed {
		logic [63:0] n;
		logic [63:0] res;
		trk_t        t;
	} root_t;

	function automatic logic [15:0] cond_neg(logic [15:0] v, logic n);
		return n ? (16'd0 - v) : v;
	endfunction

endpackage

/* sv/shape_pair_collision_test_core.sv */
// Pipelined narrow-phase collision test for a pair of circles or axis-aligned boxes.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  input   | in_valid/in_ready, first_*, second_*      | in
//  output  | out_valid/out_ready, touching, normal_*,  | out
//          | depth                                     |
//
// One transaction enters per cycle while the output is not stalled. The pipeline has
// four setup stages, sixteen square root stages of two digits each, one divider setup
// stage, the normal divider at two quotient bits per stage and the output register.
// Reset (arst_n low) clears only the stage valid bits.
// Each stage holds while the next one is full and stalled, so bubbles are squeezed out.
`include "shape_pair_collision_test_core_assert.svh"

module shape_pair_collision_test_core #(
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               first_kind,
	input  logic signed [31:0] first_center_x,
	input  logic signed [31:0] first_center_y,
	input  logic        [30:0] first_extent_x,
	input  logic        [30:0] first_extent_y,
	input  logic               second_kind,
	input  logic signed [31:0] second_center_x,
	input  logic signed [31:0] second_center_y,
	input  logic        [30:0] second_extent_x,
	input  logic        [30:0] second_extent_y,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               touching,
	output logic signed [15:0] normal_x,
	output logic signed [15:0] normal_y,
	output logic        [31:0] depth
);
	import spct_pkg::*;

	localparam int QW = NORMAL_FRAC_BITS + 1;
	localparam int NW = NORMAL_FRAC_BITS + 33;
	localparam int DS = (QW + 1) / 2;
	localparam int ROOT_STAGES = 16;
	localparam int PREP_IDX = 5 + ROOT_STAGES;
	localparam int NST = PREP_IDX + DS + 1;
	localparam logic [63:0] ONE64 = 64'd1 << NORMAL_FRAC_BITS;
	localparam logic [15:0] ONE16 = ONE64[15:0];

	typedef struct packed {
		logic [31:0]   rem_x;
		logic [31:0]   rem_y;
		logic [QW-1:0] lo_x;
		logic [QW-1:0] lo_y;
		logic [QW-1:0] q_x;
		logic [QW-1:0] q_y;
		logic [31:0]   dvsr;
		trk_t          t;
	} div_t;

	// ---------------- handshake ----------------
	logic           vld_s [0:NST];
	logic [1:NST+1] adv;

	assign vld_s[0] = in_valid;
	assign adv[NST+1] = out_ready;
	assign in_ready = adv[1];
	assign out_valid = vld_s[NST];

	for (genvar k = 1; k <= NST; k++) begin : g_vld
		assign adv[k] = !vld_s[k] || adv[k+1];
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (adv[k]) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	// ---------------- stage 1: decode and differences ----------------
	mode_t              mode_s1;
	logic               neg_s1;
	logic signed [32:0] ddx_s1, ddy_s1;
	logic signed [33:0] e_s1 [0:3];
	logic        [31:0] rsum_s1, sy_s1;

	mode_t              mode_d;
	logic               neg_d;
	logic signed [31:0] cx, cy, bx, by;
	logic        [30:0] cr, cry, bhx, bhy;

	always_comb begin
		neg_d = (first_kind == KIND_BOX) && (second_kind == KIND_CIRCLE);
		if (first_kind == KIND_CIRCLE && second_kind == KIND_CIRCLE) begin
			mode_d = MODE_CC;
		end else if (first_kind == KIND_BOX && second_kind == KIND_BOX) begin
			mode_d = MODE_BB;
		end else begin
			mode_d = MODE_CB;
		end
		cx  = neg_d ? second_center_x : first_center_x;
		cy  = neg_d ? second_center_y : first_center_y;
		cr  = neg_d ? second_extent_x : first_extent_x;
		cry = neg_d ? second_extent_y : first_extent_y;
		bx  = neg_d ? first_center_x : second_center_x;
		by  = neg_d ? first_center_y : second_center_y;
		bhx = neg_d ? first_extent_x : second_extent_x;
		bhy = neg_d ? first_extent_y : second_extent_y;
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			mode_s1 <= mode_d;
			neg_s1  <= neg_d;
			ddx_s1  <= 33'(cx) - 33'(bx);
			ddy_s1  <= 33'(cy) - 33'(by);
			// Signed distances from the circle center to the left, right, bottom, top edges.
			e_s1[0] <= 34'(cx) - 34'(bx) + 34'($signed({1'b0, bhx}));
			e_s1[1] <= 34'(bx) + 34'($signed({1'b0, bhx})) - 34'(cx);
			e_s1[2] <= 34'(cy) - 34'(by) + 34'($signed({1'b0, bhy}));
			e_s1[3] <= 34'(by) + 34'($signed({1'b0, bhy})) - 34'(cy);
			rsum_s1 <= {1'b0, cr} + ((mode_d == MODE_CB) ? 32'd0 : {1'b0, bhx});
			sy_s1   <= {1'b0, cry} + {1'b0, bhy};
		end
	end

	// ---------------- stage 2: closest point, box overlap, nearest edge ----------------
	mode_t       mode_s2;
	logic        neg_s2, sgnx_s2, sgny_s2, zero_s2;
	logic [31:0] mx_s2, my_s2, rsum_s2, best_s2;
	edge_t       edge_s2;
	logic        bbhit_s2;
	logic [15:0] bbnx_s2, bbny_s2;
	logic [31:0] bbdepth_s2;

	logic               sgnx_d, sgny_d;
	logic        [31:0] mx_d, my_d, adx, ady, best_d;
	logic signed [32:0] nddx, nddy;
	logic signed [33:0] ne0, ne1, ne2, ne3;
	logic        [32:0] ox, oy;
	edge_t              edge_d;
	logic        [15:0] bbnx_d, bbny_d;
	logic        [31:0] bbdepth_d;

	always_comb begin
		nddx = -ddx_s1;
		nddy = -ddy_s1;
		ne0 = -e_s1[0];
		ne1 = -e_s1[1];
		ne2 = -e_s1[2];
		ne3 = -e_s1[3];
		adx = ddx_s1[32] ? nddx[31:0] : ddx_s1[31:0];
		ady = ddy_s1[32] ? nddy[31:0] : ddy_s1[31:0];
		if (mode_s1 == MODE_CB) begin
			// The edge distances of an axis are never both negative.
			sgnx_d = e_s1[0][33];
			mx_d = e_s1[0][33] ? ne0[31:0] : (e_s1[1][33] ? ne1[31:0] : 32'd0);
			sgny_d = e_s1[2][33];
			my_d = e_s1[2][33] ? ne2[31:0] : (e_s1[3][33] ? ne3[31:0] : 32'd0);
		end else begin
			sgnx_d = ddx_s1[32];
			mx_d = adx;
			sgny_d = ddy_s1[32];
			my_d = ady;
		end
		best_d = e_s1[0][31:0];
		edge_d = EDGE_LEFT;
		if (e_s1[1][31:0] < best_d) begin
			best_d = e_s1[1][31:0];
			edge_d = EDGE_RIGHT;
		end
		if (e_s1[2][31:0] < best_d) begin
			best_d = e_s1[2][31:0];
			edge_d = EDGE_BOTTOM;
		end
		if (e_s1[3][31:0] < best_d) begin
			best_d = e_s1[3][31:0];
			edge_d = EDGE_TOP;
		end
		ox = {1'b0, rsum_s1} - {1'b0, adx};
		oy = {1'b0, sy_s1} - {1'b0, ady};
		if (ox[31:0] < oy[31:0]) begin
			bbdepth_d = ox[31:0];
			bbnx_d = ddx_s1[32] ? (16'd0 - ONE16) : ONE16;
			bbny_d = 16'd0;
		end else begin
			bbdepth_d = oy[31:0];
			bbnx_d = 16'd0;
			bbny_d = ddy_s1[32] ? (16'd0 - ONE16) : ONE16;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[2]) begin
			mode_s2    <= mode_s1;
			neg_s2     <= neg_s1;
			sgnx_s2    <= sgnx_d;
			sgny_s2    <= sgny_d;
			mx_s2      <= mx_d;
			my_s2      <= my_d;
			zero_s2    <= (mx_d == 32'd0) && (my_d == 32'd0);
			rsum_s2    <= rsum_s1;
			best_s2    <= best_d;
			edge_s2    <= edge_d;
			bbhit_s2   <= !ox[32] && !oy[32];
			bbnx_s2    <= bbnx_d;
			bbny_s2    <= bbny_d;
			bbdepth_s2 <= bbdepth_d;
		end
	end

	// ---------------- stage 3: squares ----------------
	mode_t       mode_s3;
	logic        neg_s3, sgnx_s3, sgny_s3, zero_s3;
	logic [31:0] mx_s3, my_s3, rsum_s3, total_s3;
	logic [63:0] ppx_s3, ppy_s3, rr_s3;
	edge_t       edge_s3;
	logic        bbhit_s3;
	logic [15:0] bbnx_s3, bbny_s3;
	logic [31:0] bbdepth_s3;
	logic [32:0] total_d;

	assign total_d = {1'b0, rsum_s2} + {1'b0, best_s2};

	always_ff @(posedge clk) begin
		if (adv[3]) begin
			mode_s3    <= mode_s2;
			neg_s3     <= neg_s2;
			sgnx_s3    <= sgnx_s2;
			sgny_s3    <= sgny_s2;
			zero_s3    <= zero_s2;
			mx_s3      <= mx_s2;
			my_s3      <= my_s2;
			rsum_s3    <= rsum_s2;
			total_s3   <= total_d[32] ? 32'hFFFF_FFFF : total_d[31:0];
			ppx_s3     <= mx_s2 * mx_s2;
			ppy_s3     <= my_s2 * my_s2;
			rr_s3      <= rsum_s2 * rsum_s2;
			edge_s3    <= edge_s2;
			bbhit_s3   <= bbhit_s2;
			bbnx_s3    <= bbnx_s2;
			bbny_s3    <= bbny_s2;
			bbdepth_s3 <= bbdepth_s2;
		end
	end

	// ---------------- stage 4: hit test and fixed results ----------------
	root_t root_s [0:ROOT_STAGES];

	logic [64:0] sum_d;
	logic        hit_d;
	trk_t        trk_d;
	logic [15:0] spx, spy;

	always_comb begin
		sum_d = {1'b0, ppx_s3} + {1'b0, ppy_s3};
		hit_d = !sum_d[64] && (sum_d[63:0] <= rr_s3);
		if (mode_s3 == MODE_CC) begin
			spx = 16'd0;
			spy = 16'd0 - ONE16;
		end else begin
			unique case (edge_s3)
				EDGE_LEFT: begin
					spx = 16'd0 - ONE16;
					spy = 16'd0;
				end
				EDGE_RIGHT: begin
					spx = ONE16;
					spy = 16'd0;
				end
				EDGE_BOTTOM: begin
					spx = 16'd0;
					spy = 16'd0 - ONE16;
				end
				EDGE_TOP: begin
					spx = 16'd0;
					spy = ONE16;
				end
				default: begin
					spx = 16'd0;
					spy = 16'd0;
				end
			endcase
		end
		trk_d.mag_x = mx_s3;
		trk_d.mag_y = my_s3;
		trk_d.rsum = rsum_s3;
		trk_d.neg_x = neg_s3 ^ sgnx_s3;
		trk_d.neg_y = neg_s3 ^ sgny_s3;
		unique case (mode_s3)
			MODE_BB: begin
				trk_d.hit = bbhit_s3;
				trk_d.use_root = 1'b0;
				trk_d.fix_nx = bbhit_s3 ? bbnx_s3 : 16'd0;
				trk_d.fix_ny = bbhit_s3 ? bbny_s3 : 16'd0;
				trk_d.fix_depth = bbhit_s3 ? bbdepth_s3 : 32'd0;
			end
			MODE_CC, MODE_CB: begin
				trk_d.hit = hit_d;
				trk_d.use_root = hit_d && !zero_s3;
				trk_d.fix_nx = (hit_d && zero_s3) ? cond_neg(spx, neg_s3) : 16'd0;
				trk_d.fix_ny = (hit_d && zero_s3) ? cond_neg(spy, neg_s3) : 16'd0;
				if (!hit_d || !zero_s3) begin
					trk_d.fix_depth = 32'd0;
				end else if (mode_s3 == MODE_CC) begin
					trk_d.fix_depth = rsum_s3;
				end else begin
					trk_d.fix_depth = total_s3;
				end
			end
			default: begin
				trk_d.hit = 1'b0;
				trk_d.use_root = 1'b0;
				trk_d.fix_nx = 16'd0;
				trk_d.fix_ny = 16'd0;
				trk_d.fix_depth = 32'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv[4]) begin
			root_s[0].n   <= sum_d[63:0];
			root_s[0].res <= 64'd0;
			root_s[0].t   <= trk_d;
		end
	end

	// ---------------- square root, two digits per stage ----------------
	for (genvar j = 1; j <= ROOT_STAGES; j++) begin : g_root
		root_t nxt;
		always_comb begin
			logic [63:0] n, res, bitv;
			n = root_s[j-1].n;
			res = root_s[j-1].res;
			for (int k = 0; k < 2; k++) begin
				bitv = 64'h4000_0000_0000_0000 >> (4 * (j - 1) + 2 * k);
				if (n >= res + bitv) begin
					n = n - (res + bitv);
					res = (res >> 1) + bitv;
				end else begin
					res = res >> 1;
				end
			end
			nxt.n = n;
			nxt.res = res;
			nxt.t = root_s[j-1].t;
		end
		always_ff @(posedge clk) begin
			if (adv[4+j]) begin
				root_s[j] <= nxt;
			end
		end
	end

	// ---------------- divider setup ----------------
	div_t div_s [0:DS];

	logic [31:0]   dist_d;
	logic [NW-1:0] numx, numy;
	div_t          prep_d;

	always_comb begin
		dist_d = root_s[ROOT_STAGES].res[31:0];
		// Adding half the divisor rounds the quotient to nearest.
		numx = (NW'(root_s[ROOT_STAGES].t.mag_x) << NORMAL_FRAC_BITS) + NW'(dist_d >> 1);
		numy = (NW'(root_s[ROOT_STAGES].t.mag_y) << NORMAL_FRAC_BITS) + NW'(dist_d >> 1);
		prep_d.rem_x = numx[NW-1:QW];
		prep_d.rem_y = numy[NW-1:QW];
		prep_d.lo_x = numx[QW-1:0];
		prep_d.lo_y = numy[QW-1:0];
		prep_d.q_x = '0;
		prep_d.q_y = '0;
		prep_d.dvsr = dist_d;
		prep_d.t = root_s[ROOT_STAGES].t;
		if (root_s[ROOT_STAGES].t.use_root) begin
			prep_d.t.fix_depth = root_s[ROOT_STAGES].t.rsum - dist_d;
		end
	end

	always_ff @(posedge clk) begin
		if (adv[PREP_IDX]) begin
			div_s[0] <= prep_d;
		end
	end

	// ---------------- normal divider, two quotient bits per stage ----------------
	for (genvar j = 1; j <= DS; j++) begin : g_div
		div_t nxt;
		always_comb begin
			logic [32:0] tx, ty;
			nxt = div_s[j-1];
			for (int k = 0; k < 2; k++) begin
				if (2 * (j - 1) + k < QW) begin
					tx = {nxt.rem_x, nxt.lo_x[QW-1]};
					ty = {nxt.rem_y, nxt.lo_y[QW-1]};
					nxt.lo_x = nxt.lo_x << 1;
					nxt.lo_y = nxt.lo_y << 1;
					if (tx >= {1'b0, nxt.dvsr}) begin
						tx = tx - {1'b0, nxt.dvsr};
						nxt.q_x = {nxt.q_x[QW-2:0], 1'b1};
					end else begin
						nxt.q_x = {nxt.q_x[QW-2:0], 1'b0};
					end
					if (ty >= {1'b0, nxt.dvsr}) begin
						ty = ty - {1'b0, nxt.dvsr};
						nxt.q_y = {nxt.q_y[QW-2:0], 1'b1};
					end else begin
						nxt.q_y = {nxt.q_y[QW-2:0], 1'b0};
					end
					nxt.rem_x = tx[31:0];
					nxt.rem_y = ty[31:0];
				end
			end
		end
		always_ff @(posedge clk) begin
			if (adv[PREP_IDX+j]) begin
				div_s[j] <= nxt;
			end
		end
	end

	// ---------------- output register ----------------
	logic        touch_q;
	logic [15:0] nx_q, ny_q;
	logic [31:0] depth_q;
	trk_t        fin;

	assign fin = div_s[DS].t;

	always_ff @(posedge clk) begin
		if (adv[NST]) begin
			touch_q <= fin.hit;
			nx_q    <= fin.use_root ? cond_neg(16'(div_s[DS].q_x), fin.neg_x) : fin.fix_nx;
			ny_q    <= fin.use_root ? cond_neg(16'(div_s[DS].q_y), fin.neg_y) : fin.fix_ny;
			depth_q <= fin.fix_depth;
		end
	end

	assign touching = touch_q;
	assign normal_x = $signed(nx_q);
	assign normal_y = $signed(ny_q);
	assign depth = depth_q;

	// ---------------- checks ----------------
	`SPCT_ASSERT_NOW(a_miss_is_zero, out_valid && !touching,
		normal_x == 16'sd0 && normal_y == 16'sd0 && depth == 32'd0)
	`SPCT_ASSERT_NEXT(a_accept_fills_s1, in_valid && in_ready, vld_s[1])
	`SPCT_ASSERT_NOW(a_ready_drop_only_full, !in_ready, vld_s[1])

endmodule

/* bench/shape_pair_collision_test_core_checker.sv */
// Checker for the collision test core: predicts each contact and compares the outputs.
module shape_pair_collision_test_core_checker #(
	parameter int NORMAL_FRAC_BITS = 14
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               first_kind,
	input  logic signed [31:0] first_center_x,
	input  logic signed [31:0] first_center_y,
	input  logic        [30:0] first_extent_x,
	input  logic        [30:0] first_extent_y,
	input  logic               second_kind,
	input  logic signed [31:0] second_center_x,
	input  logic signed [31:0] second_center_y,
	input  logic        [30:0] second_extent_x,
	input  logic        [30:0] second_extent_y,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               touching,
	input  logic signed [15:0] normal_x,
	input  logic signed [15:0] normal_y,
	input  logic        [31:0] depth,
	output int                 errors,
	output int                 pending
);
	import spct_pkg::*;

	typedef struct {
		logic            hit;
		longint          nx;
		longint          ny;
		longint unsigned dep;
	} contact_t;

	typedef struct {
		logic        touching;
		logic [15:0] normal_x;
		logic [15:0] normal_y;
		logic [31:0] depth;
	} contact_out_t;

	contact_out_t expected_contacts[$];

	function automatic longint unsigned abs_val(longint d);
		return d < 0 ? longint'(-d) : longint'(d);
	endfunction

	function automatic longint unsigned int_sqrt(longint unsigned n);
		longint unsigned res;
		longint unsigned b;
		res = 0;
		b = 64'd1 << 62;
		while (b > n)
			b = b >> 2;
		while (b != 0) begin
			if (n >= res + b) begin
				n = n - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		return res;
	endfunction

	// Rounded to nearest, halves away from zero.
	function automatic longint unit_comp(longint d, longint unsigned dlen);
		longint unsigned q;
		q = ((abs_val(d) << NORMAL_FRAC_BITS) + dlen / 2) / dlen;
		return d < 0 ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [64:0] dist_sq(longint dx, longint dy);
		logic [64:0] a;
		logic [64:0] b;
		a = {1'b0, abs_val(dx) * abs_val(dx)};
		b = {1'b0, abs_val(dy) * abs_val(dy)};
		return a + b;
	endfunction

	function automatic contact_t circle_circle(longint ax, longint ay, longint unsigned ar,
			longint bx, longint by, longint unsigned br);
		contact_t c;
		longint dx;
		longint dy;
		longint unsigned r;
		logic [64:0] sq;
		longint unsigned dlen;
		c = '{1'b0, 0, 0, 0};
		dx = ax - bx;
		dy = ay - by;
		r = ar + br;
		sq = dist_sq(dx, dy);
		if (sq[64] || sq[63:0] > r * r)
			return c;
		c.hit = 1'b1;
		if (sq == 0) begin
			c.ny = -(64'sd1 << NORMAL_FRAC_BITS);
			c.dep = r;
		end else begin
			dlen = int_sqrt(sq[63:0]);
			c.nx = unit_comp(dx, dlen);
			c.ny = unit_comp(dy, dlen);
			c.dep = r - dlen;
		end
		return c;
	endfunction

	function automatic contact_t box_box(longint ax, longint ay, longint unsigned ahx,
			longint unsigned ahy, longint bx, longint by, longint unsigned bhx,
			longint unsigned bhy);
		contact_t c;
		longint unsigned adx;
		longint unsigned ady;
		longint unsigned sx;
		longint unsigned sy;
		longint one;
		c = '{1'b0, 0, 0, 0};
		adx = abs_val(ax - bx);
		ady = abs_val(ay - by);
		sx = ahx + bhx;
		sy = ahy + bhy;
		one = 64'sd1 << NORMAL_FRAC_BITS;
		if (adx > sx || ady > sy)
			return c;
		c.hit = 1'b1;
		// A tie between the two overlaps goes to the y axis.
		if (sx - adx < sy - ady) begin
			c.dep = sx - adx;
			c.nx = (ax < bx) ? -one : one;
		end else begin
			c.dep = sy - ady;
			c.ny = (ay < by) ? -one : one;
		end
		return c;
	endfunction

	function automatic longint clamp_to(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic contact_t circle_box(longint cx, longint cy, longint unsigned rad,
			longint bx, longint by, longint unsigned hx, longint unsigned hy);
		contact_t c;
		longint lox;
		longint hix;
		longint loy;
		longint hiy;
		longint dx;
		longint dy;
		longint one;
		logic [64:0] sq;
		longint unsigned best;
		longint unsigned total;
		longint unsigned dlen;
		c = '{1'b0, 0, 0, 0};
		lox = bx - longint'(hx);
		hix = bx + longint'(hx);
		loy = by - longint'(hy);
		hiy = by + longint'(hy);
		dx = cx - clamp_to(cx, lox, hix);
		dy = cy - clamp_to(cy, loy, hiy);
		one = 64'sd1 << NORMAL_FRAC_BITS;
		sq = dist_sq(dx, dy);
		if (sq[64] || sq[63:0] > rad * rad)
			return c;
		c.hit = 1'b1;
		if (sq == 0) begin
			// Center inside the box: the nearest edge wins, earlier edges on a tie.
			best = cx - lox;
			c.nx = -one;
			if (longint'(hix - cx) < best) begin
				best = hix - cx;
				c.nx = one;
				c.ny = 0;
			end
			if (longint'(cy - loy) < best) begin
				best = cy - loy;
				c.nx = 0;
				c.ny = -one;
			end
			if (longint'(hiy - cy) < best) begin
				best = hiy - cy;
				c.nx = 0;
				c.ny = one;
			end
			total = rad + best;
			c.dep = total > 64'hFFFF_FFFF ? 64'hFFFF_FFFF : total;
		end else begin
			dlen = int_sqrt(sq[63:0]);
			c.nx = unit_comp(dx, dlen);
			c.ny = unit_comp(dy, dlen);
			c.dep = rad - dlen;
		end
		return c;
	endfunction

	function automatic contact_out_t predict_contact();
		contact_t c;
		contact_out_t o;
		longint ax;
		longint ay;
		longint bx;
		longint by;
		ax = longint'(first_center_x);
		ay = longint'(first_center_y);
		bx = longint'(second_center_x);
		by = longint'(second_center_y);
		if (first_kind == KIND_CIRCLE && second_kind == KIND_CIRCLE) begin
			c = circle_circle(ax, ay, first_extent_x, bx, by, second_extent_x);
		end else if (first_kind == KIND_CIRCLE) begin
			c = circle_box(ax, ay, first_extent_x, bx, by, second_extent_x, second_extent_y);
		end else if (second_kind == KIND_CIRCLE) begin
			c = circle_box(bx, by, second_extent_x, ax, ay, first_extent_x, first_extent_y);
			c.nx = -c.nx;
			c.ny = -c.ny;
		end else begin
			c = box_box(ax, ay, first_extent_x, first_extent_y,
				bx, by, second_extent_x, second_extent_y);
		end
		o.touching = c.hit;
		o.normal_x = c.hit ? c.nx[15:0] : 16'd0;
		o.normal_y = c.hit ? c.ny[15:0] : 16'd0;
		o.depth = c.hit ? c.dep[31:0] : 32'd0;
		return o;
	endfunction

	assign pending = expected_contacts.size();

	initial errors = 0;

	always @(posedge clk) begin
		contact_out_t exp_c;
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_contacts.push_back(predict_contact());
			if (out_valid && out_ready) begin
				if (expected_contacts.size() == 0) begin
					$error("unexpected result transaction");
					errors++;
				end else begin
					exp_c = expected_contacts.pop_front();
					if (touching !== exp_c.touching) begin
						$error("touching: expected %0d, actual %0d", exp_c.touching, touching);
						errors++;
					end
					if (normal_x !== exp_c.normal_x) begin
						$error("normal_x: expected %0d, actual %0d",
							$signed(exp_c.normal_x), normal_x);
						errors++;
					end
					if (normal_y !== exp_c.normal_y) begin
						$error("normal_y: expected %0d, actual %0d",
							$signed(exp_c.normal_y), normal_y);
						errors++;
					end
					if (depth !== exp_c.depth) begin
						$error("depth: expected %0h, actual %0h", exp_c.depth, depth);
						errors++;
					end
				end
			end
		end
	end

endmodule

/* bench/shape_pair_collision_test_core_tb.sv */
// Testbench top for the collision test core: stimulus, reset, watchdog and verdict.
module shape_pair_collision_test_core_tb;
	import spct_pkg::*;

	localparam int IDLE_LIMIT = 3000;
	localparam int RANDOM_ITEMS = 600;
	localparam int HOLD_CYCLES = 300;
	localparam longint ONE = 65536;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic               first_kind;
	logic signed [31:0] first_center_x;
	logic signed [31:0] first_center_y;
	logic        [30:0] first_extent_x;
	logic        [30:0] first_extent_y;
	logic               second_kind;
	logic signed [31:0] second_center_x;
	logic signed [31:0] second_center_y;
	logic        [30:0] second_extent_x;
	logic        [30:0] second_extent_y;
	logic               out_valid;
	logic               out_ready;
	logic               touching;
	logic signed [15:0] normal_x;
	logic signed [15:0] normal_y;
	logic        [31:0] depth;
	int                 errors;
	int                 pending;
	int                 pairs_sent;
	int                 idle_cycles;
	int                 burst_left;

	shape_pair_collision_test_core uut (.*);

	shape_pair_collision_test_core_checker chk (.*);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// Most gaps are short, a few long, and bursts run with none at all.
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		else if (p < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(10, 40);
	endfunction

	task automatic send_pair(logic fk, longint fx, longint fy, longint fex, longint fey,
			logic sk, longint sx, longint sy, longint sex, longint sey);
		int gap;
		first_kind <= fk;
		first_center_x <= fx[31:0];
		first_center_y <= fy[31:0];
		first_extent_x <= fex[30:0];
		first_extent_y <= fey[30:0];
		second_kind <= sk;
		second_center_x <= sx[31:0];
		second_center_y <= sy[31:0];
		second_extent_x <= sex[30:0];
		second_extent_y <= sey[30:0];
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		pairs_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			if ($urandom_range(0, 29) == 0)
				burst_left = $urandom_range(20, 60);
			gap = pick_gap();
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic send_random_pair();
		longint bx;
		longint by;
		if ($urandom_range(0, 99) < 80) begin
			// Neighbouring shapes, so that most pairs come close to touching.
			bx = $signed($urandom_range(0, 32'h7FFF_FFFF)) - 64'sh4000_0000;
			by = $signed($urandom_range(0, 32'h7FFF_FFFF)) - 64'sh4000_0000;
			send_pair(1'($urandom_range(0, 1)),
				bx + $signed($urandom_range(0, 2 << 20)) - (1 << 20),
				by + $signed($urandom_range(0, 2 << 20)) - (1 << 20),
				$urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20),
				1'($urandom_range(0, 1)), bx, by,
				$urandom_range(0, 1 << 20), $urandom_range(0, 1 << 20));
		end else begin
			send_pair(1'($urandom_range(0, 1)), $signed($urandom), $signed($urandom),
				$urandom, $urandom, 1'($urandom_range(0, 1)), $signed($urandom),
				$signed($urandom), $urandom, $urandom);
		end
	endtask

	// Receiver: random stalls, plus one long hold-off that fills the pipeline.
	initial begin
		bit held;
		int p;
		held = 0;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held && pairs_sent >= 200) begin
				held = 1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				p = $urandom_range(0, 99);
				if (p < 70 || burst_left > 0) begin
					out_ready <= 1'b1;
					@(posedge clk);
				end else begin
					out_ready <= 1'b0;
					repeat (p < 95 ? $urandom_range(1, 3) : $urandom_range(10, 40))
						@(posedge clk);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("** shape_pair_collision_test_core: FAILED **");
				$finish;
			end
		end
	end

	initial begin
		pairs_sent = 0;
		burst_left = 0;
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		first_kind <= KIND_CIRCLE;
		first_center_x <= '0;
		first_center_y <= '0;
		first_extent_x <= '0;
		first_extent_y <= '0;
		second_kind <= KIND_CIRCLE;
		second_center_x <= '0;
		second_center_y <= '0;
		second_extent_x <= '0;
		second_extent_y <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Circle against circle: coincident, exact touch, miss, diagonal, overflow, zero radius.
		send_pair(KIND_CIRCLE, 0, 0, 5 * ONE, 0, KIND_CIRCLE, 0, 0, 3 * ONE, 0);
		send_pair(KIND_CIRCLE, 10 * ONE, 0, 4 * ONE, 0, KIND_CIRCLE, 0, 0, 6 * ONE, 0);
		send_pair(KIND_CIRCLE, 11 * ONE, 0, 4 * ONE, 0, KIND_CIRCLE, 0, 0, 6 * ONE, 0);
		send_pair(KIND_CIRCLE, 3 * ONE, -4 * ONE, 3 * ONE, 0, KIND_CIRCLE, 0, 0, 3 * ONE, 0);
		send_pair(KIND_CIRCLE, -64'sh8000_0000, -64'sh8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			KIND_CIRCLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		send_pair(KIND_CIRCLE, 7, 7, 0, 0, KIND_CIRCLE, 7, 7, 0, 0);
		// Box against box: x axis, tie, equal centers, miss, first on the low side, extreme coordinates.
		send_pair(KIND_BOX, 3 * ONE, 0, 2 * ONE, 5 * ONE, KIND_BOX, 0, 0, 2 * ONE, 5 * ONE);
		send_pair(KIND_BOX, 1 * ONE, 1 * ONE, 2 * ONE, 2 * ONE, KIND_BOX, 0, 0, 2 * ONE, 2 * ONE);
		send_pair(KIND_BOX, 0, 0, ONE, 3 * ONE, KIND_BOX, 0, 0, 2 * ONE, ONE);
		send_pair(KIND_BOX, 9 * ONE, 0, ONE, ONE, KIND_BOX, 0, 0, ONE, ONE);
		send_pair(KIND_BOX, -3 * ONE, -ONE, 2 * ONE, 5 * ONE, KIND_BOX, 0, 0, 2 * ONE, 5 * ONE);
		send_pair(KIND_BOX, -64'sh8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			KIND_BOX, 32'h7FFF_FFFF, -64'sh8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		// Circle inside a box, nearest edge left, right, bottom, top, then all equal.
		send_pair(KIND_CIRCLE, -8 * ONE, 0, ONE, 0, KIND_BOX, 0, 0, 10 * ONE, 10 * ONE);
		send_pair(KIND_CIRCLE, 8 * ONE, 0, ONE, 0, KIND_BOX, 0, 0, 10 * ONE, 10 * ONE);
		send_pair(KIND_CIRCLE, 0, -8 * ONE, ONE, 0, KIND_BOX, 0, 0, 10 * ONE, 10 * ONE);
		send_pair(KIND_CIRCLE, 0, 8 * ONE, ONE, 0, KIND_BOX, 0, 0, 10 * ONE, 10 * ONE);
		send_pair(KIND_CIRCLE, 0, 0, ONE, 0, KIND_BOX, 0, 0, 10 * ONE, 10 * ONE);
		send_pair(KIND_CIRCLE, 0, 0, 32'h7FFF_FFFF, 0, KIND_BOX, 0, 0, 32'h7FFF_FFFF,
			32'h7FFF_FFFF);
		// Circle outside a box: corner hit and miss, then the swapped order, also with the circle inside.
		send_pair(KIND_CIRCLE, 13 * ONE, 14 * ONE, 5 * ONE, 0, KIND_BOX, 0, 0,
			10 * ONE, 10 * ONE);
		send_pair(KIND_CIRCLE, 15 * ONE, 15 * ONE, 5 * ONE, 0, KIND_BOX, 0, 0,
			10 * ONE, 10 * ONE);
		send_pair(KIND_BOX, 0, 0, 10 * ONE, 10 * ONE, KIND_CIRCLE, 13 * ONE, 14 * ONE,
			5 * ONE, 0);
		send_pair(KIND_BOX, 0, 0, 10 * ONE, 10 * ONE, KIND_CIRCLE, 0, 8 * ONE, ONE, 0);

		repeat (RANDOM_ITEMS) send_random_pair();
		in_valid <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("** shape_pair_collision_test_core: PASSED **");
		else
			$display("** shape_pair_collision_test_core: FAILED **");
		$finish;
	end

endmodule

/* shape_pair_collision_test_core.f */
+incdir+sv
sv/spct_pkg.sv
sv/shape_pair_collision_test_core.sv
bench/shape_pair_collision_test_core_checker.sv
bench/shape_pair_collision_test_core_tb.sv
